// File: rtl/assert_macros.svh
// assertion macros shared by the route sequencer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/wrs_pkg.sv
// types and constants of the waypoint route sequencer
package wrs_pkg;

  localparam int CW      = 24;
  localparam int MAX_WP  = 64;
  localparam int IDX_W   = $clog2(MAX_WP + 1);
  localparam int ADDR_W  = $clog2(MAX_WP);
  localparam int HOLD_W  = 17;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int REQ_W   = 3;
  localparam int MODE_W  = 3;
  localparam int PROD_W  = 2 * CW;
  localparam int ACC_W   = 2 * CW + 2;

  localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ADD   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_START = 3'd2;
  localparam logic [REQ_W-1:0] REQ_TICK  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_STOP  = 3'd4;
  localparam logic [REQ_W-1:0] REQ_RESET = 3'd5;

  localparam logic [MODE_W-1:0] MODE_NONE     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INIT     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_GOTO     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FOLLOW   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_HOLD     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_FINISHED = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_PROXIMITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT    = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]     req_type;
    logic signed [CW-1:0] waypoint_x;
    logic signed [CW-1:0] waypoint_y;
    logic signed [CW-1:0] waypoint_z;
    logic signed [CW-1:0] vehicle_x;
    logic signed [CW-1:0] vehicle_y;
    logic signed [CW-1:0] vehicle_z;
    logic                 from_beginning;
  } item_t;

  typedef struct packed {
    logic                 goto_valid;
    logic signed [CW-1:0] goto_x;
    logic signed [CW-1:0] goto_y;
    logic signed [CW-1:0] goto_z;
    logic [MODE_W-1:0]    fsm_code;
    logic [IDX_W-1:0]     current_index;
    logic                 running;
    logic                 add_dropped;
  } result_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } wp_t;

  typedef struct packed {
    logic       capture;
    logic       plan;
    logic       sq;
    logic [1:0] sq_step;
    logic       exec;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_dist;
  } ctrl_stat_t;

endpackage

// File: rtl/waypoint_route_sequencer.sv
// top level of the waypoint route sequencer
//
// Request channel: a transaction is taken at a rising edge with start high and
// busy low; the request struct carries one command (clear, add waypoint, start,
// tick, stop, reset) and its coordinates. Every request yields one result.
// Result channel: done is high for exactly one cycle with the result struct;
// the receiver must take it then, it cannot stall the block.
// Sequence: each request passes through a plan state and an execute state
// before the registered result shows; a tick in the following state first runs
// the squared distance and squared radius through one shared 24x24 multiplier
// in the distance steps. busy drops in the cycle that shows the result, so a
// new request is taken only once the result of the last one shows.
// Configuration: cfg_valid with cfg_index (0 radius, 1 hold ticks, 2 repeat)
// and cfg_data; cfg_ready is always high, writes belong in idle periods.
// Reset (rst, synchronous): radius 1000, hold 10 ticks, no repeat, empty
// route, state none, not running. Route table contents are not cleared.
module waypoint_route_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  wrs_pkg::item_t                request,
  output logic                          done,
  output wrs_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wrs_pkg::CFG_W-1:0]     cfg_data
);
  import wrs_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  assign cfg_ready = 1'b1;

  wrs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  wrs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .result    (result)
  );

endmodule

// File: rtl/wrs_ctrl.sv
// sequencing state machine of the route sequencer
`include "assert_macros.svh"

module wrs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  wrs_pkg::ctrl_stat_t stat,
  output wrs_pkg::ctrl_cmd_t  cmd
);
  import wrs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PLAN = 2'd1;
  localparam logic [1:0] S_SQ   = 2'd2;
  localparam logic [1:0] S_EXEC = 2'd3;

  logic [1:0] state;
  logic [1:0] step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= 2'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) state <= S_PLAN;
        end
        S_PLAN: begin
          step  <= 2'd0;
          state <= stat.need_dist ? S_SQ : S_EXEC;
        end
        S_SQ: begin
          step <= step + 2'd1;
          if (step == 2'd3) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy        = (state != S_IDLE);
  assign cmd.capture = (state == S_IDLE) && start;
  assign cmd.plan    = (state == S_PLAN);
  assign cmd.sq      = (state == S_SQ);
  assign cmd.sq_step = step;
  assign cmd.exec    = (state == S_EXEC);

  `ASSERT_NEXT(a_accept_plan, clk, rst, start && !busy, state == S_PLAN,
               "accepted transaction did not enter planning")
  `ASSERT_NEXT(a_sq_end, clk, rst, state == S_SQ && step == 2'd3, state == S_EXEC,
               "distance sequence did not end in execute")
  `ASSERT_NEXT(a_exec_once, clk, rst, state == S_EXEC, state == S_IDLE,
               "execute lasted more than one cycle")

endmodule

// File: rtl/wrs_datapath.sv
// route table, goal registers, distance unit and result register
`include "assert_macros.svh"

module wrs_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  wrs_pkg::item_t              request,
  input  logic                        cfg_valid,
  input  logic [wrs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wrs_pkg::CFG_W-1:0]   cfg_data,
  input  wrs_pkg::ctrl_cmd_t          cmd,
  output wrs_pkg::ctrl_stat_t         stat,
  output logic                        done,
  output wrs_pkg::result_t            result
);
  import wrs_pkg::*;

  // configuration
  logic [CFG_W-1:0] proximity;
  logic [CFG_W-1:0] hold_ticks;
  logic             repeat_route;

  // captured transaction
  item_t item;

  // route state
  wp_t                  route_mem [MAX_WP];
  wp_t                  rd_data;
  logic [IDX_W-1:0]     route_count;
  logic [IDX_W-1:0]     goal_index;
  logic [MODE_W-1:0]    mode;
  wp_t                  goal;
  logic signed [CW-1:0] saved_alt;
  logic [HOLD_W-1:0]    hold_count;
  logic                 ticking;

  // distance unit
  logic [CW-1:0]     dx, dy, dz;
  logic [CW-1:0]     sq_op;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0]  acc;
  logic              dist_lt;

  // execute outcome
  logic [IDX_W-1:0]     route_count_next;
  logic [IDX_W-1:0]     goal_index_next;
  logic [MODE_W-1:0]    mode_next;
  wp_t                  goal_next;
  logic signed [CW-1:0] saved_alt_next;
  logic [HOLD_W-1:0]    hold_count_next;
  logic                 ticking_next;
  logic                 go;
  wp_t                  go_pos;
  logic                 dropped;
  logic                 wr_en;
  logic [IDX_W-1:0]     gi_inc;
  logic [ADDR_W-1:0]    rd_addr;
  wp_t                  loaded;

  function automatic logic [CW-1:0] abs_diff(logic signed [CW-1:0] a,
                                             logic signed [CW-1:0] b);
    logic signed [CW:0] d;
    logic        [CW:0] n;
    d = {a[CW-1], a} - {b[CW-1], b};
    n = -d;
    return d[CW] ? n[CW-1:0] : d[CW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      proximity    <= CFG_W'(1000);
      hold_ticks   <= CFG_W'(10);
      repeat_route <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PROXIMITY: proximity    <= cfg_data;
        CFG_HOLD:      hold_ticks   <= cfg_data;
        CFG_REPEAT:    repeat_route <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item <= request;
  end

  // next goal index with saturation at the table size
  assign gi_inc  = (goal_index < IDX_W'(MAX_WP)) ? goal_index + IDX_W'(1) : goal_index;
  assign rd_addr = (mode == MODE_INIT) ? '0 : gi_inc[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en)
      route_mem[route_count[ADDR_W-1:0]] <= '{x: item.waypoint_x, y: item.waypoint_y,
                                               z: item.waypoint_z};
  end

  always_ff @(posedge clk) begin
    if (cmd.plan) rd_data <= route_mem[rd_addr];
  end

  assign stat.need_dist = (item.req_type == REQ_TICK) && ticking && (mode == MODE_FOLLOW);

  // one shared squarer: dx, dy, dz, then the proximity radius
  always_comb begin
    case (cmd.sq_step)
      2'd0:    sq_op = dx;
      2'd1:    sq_op = dy;
      2'd2:    sq_op = dz;
      default: sq_op = CW'(proximity);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.plan) begin
      dx  <= abs_diff(item.vehicle_x, goal.x);
      dy  <= abs_diff(item.vehicle_y, goal.y);
      dz  <= abs_diff(item.vehicle_z, goal.z);
      acc <= '0;
    end
    if (cmd.sq) begin
      prod <= sq_op * sq_op;
      if (cmd.sq_step != 2'd0) acc <= acc + ACC_W'(prod);
    end
  end

  assign dist_lt = acc < ACC_W'(prod);

  always_comb begin
    loaded   = rd_data;
    if (!saved_alt[CW-1] && (saved_alt != '0)) loaded.z = saved_alt;

    route_count_next = route_count;
    goal_index_next  = goal_index;
    mode_next        = mode;
    goal_next        = goal;
    saved_alt_next   = saved_alt;
    hold_count_next  = hold_count;
    ticking_next     = ticking;
    go               = 1'b0;
    go_pos           = '0;
    dropped          = 1'b0;
    wr_en            = 1'b0;

    case (item.req_type)
      REQ_CLEAR: route_count_next = '0;
      REQ_ADD: begin
        if (route_count < IDX_W'(MAX_WP)) begin
          wr_en            = 1'b1;
          route_count_next = route_count + IDX_W'(1);
        end else begin
          dropped = 1'b1;
        end
      end
      REQ_START: begin
        saved_alt_next = item.vehicle_z;
        mode_next      = (item.from_beginning || mode == MODE_NONE) ? MODE_INIT : MODE_GOTO;
        ticking_next   = 1'b1;
      end
      REQ_TICK: begin
        if (ticking) begin
          unique case (mode)
            MODE_INIT: begin
              if (route_count != '0) begin
                goal_index_next = '0;
                goal_next       = loaded;
                mode_next       = MODE_GOTO;
              end else begin
                mode_next = MODE_FINISHED;
              end
            end
            MODE_GOTO: begin
              go        = 1'b1;
              go_pos    = goal;
              mode_next = MODE_FOLLOW;
            end
            MODE_FOLLOW: begin
              if (dist_lt) mode_next = MODE_HOLD;
            end
            MODE_HOLD: begin
              if (hold_count >= HOLD_W'(hold_ticks)) begin
                hold_count_next = '0;
                goal_index_next = gi_inc;
                if (gi_inc < route_count) begin
                  goal_next = loaded;
                  mode_next = MODE_GOTO;
                end else begin
                  mode_next = repeat_route ? MODE_INIT : MODE_FINISHED;
                end
              end else begin
                hold_count_next = hold_count + HOLD_W'(1);
              end
            end
            MODE_FINISHED: begin
              mode_next       = MODE_NONE;
              goal_index_next = route_count;
              ticking_next    = 1'b0;
              go              = 1'b1;
              go_pos          = '{x: item.vehicle_x, y: item.vehicle_y, z: item.vehicle_z};
            end
            default: ;
          endcase
        end
      end
      REQ_STOP: begin
        ticking_next = 1'b0;
        go           = 1'b1;
        go_pos       = '{x: item.vehicle_x, y: item.vehicle_y, z: item.vehicle_z};
      end
      REQ_RESET: begin
        ticking_next    = 1'b0;
        mode_next       = MODE_NONE;
        goal_index_next = route_count;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      route_count <= '0;
      goal_index  <= '0;
      mode        <= MODE_NONE;
      goal        <= '0;
      saved_alt   <= '0;
      hold_count  <= '0;
      ticking     <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= cmd.exec;
      if (cmd.exec) begin
        route_count <= route_count_next;
        goal_index  <= goal_index_next;
        mode        <= mode_next;
        goal        <= goal_next;
        saved_alt   <= saved_alt_next;
        hold_count  <= hold_count_next;
        ticking     <= ticking_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      result.goto_valid    <= go;
      result.goto_x        <= go_pos.x;
      result.goto_y        <= go_pos.y;
      result.goto_z        <= go_pos.z;
      result.fsm_code      <= mode_next;
      result.current_index <= goal_index_next;
      result.running       <= ticking_next;
      result.add_dropped   <= dropped;
    end
  end

  `ASSERT_NEXT(a_exec_done, clk, rst, cmd.exec, done,
               "execute not followed by a result strobe")
  `ASSERT_IMPL(a_drop_full, clk, rst, done && result.add_dropped,
               route_count == IDX_W'(MAX_WP), "add refused while table not full")
  `ASSERT_IMPL(a_running, clk, rst, done, result.running == ticking,
               "reported running flag differs from state")

endmodule
